[rtl/sist_pkg.sv]
// Shared types and constants of the small integer set table.
// No dependencies; included by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package sist_pkg;

   localparam int unsigned KEY_W         = 32;
   localparam int unsigned OPCODE_W      = 2;
   localparam int unsigned ENTRY_COUNT_W = 5;
   localparam int unsigned DEF_CAPACITY  = 16;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

   typedef struct packed {
      logic                     was_present;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     full_drop;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/sist_key_ram.sv]
// Key storage of the set table: one write port, one read port, registered read.
// Depends on sist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sist_key_ram #(
   parameter int unsigned DEPTH  = sist_pkg::DEF_CAPACITY,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [sist_pkg::KEY_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [sist_pkg::KEY_W-1:0] rd_data
);
   import sist_pkg::*;

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/sist_seq.sv]
// Request sequencer: scans the key memory, appends or shifts entries, holds the response.
// Depends on sist_pkg and drives sist_key_ram.
`timescale 1ns / 1ps
`default_nettype none

module sist_seq #(
   parameter int unsigned CAPACITY = sist_pkg::DEF_CAPACITY,
   parameter int unsigned IDX_W    = 4,
   parameter int unsigned CNT_W    = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sist_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [sist_pkg::KEY_W-1:0]    req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output sist_pkg::rsp_type                  rsp_data,
   output logic                               ram_wr_en,
   output logic      [IDX_W-1:0]              ram_wr_addr,
   output logic      [sist_pkg::KEY_W-1:0]    ram_wr_data,
   output logic                               ram_rd_en,
   output logic      [IDX_W-1:0]              ram_rd_addr,
   input  wire logic [sist_pkg::KEY_W-1:0]    ram_rd_data
);
   import sist_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

   logic [1:0]          state_ff,     state_in;
   logic [OPCODE_W-1:0] op_ff,        op_in;
   logic [KEY_W-1:0]    key_ff,       key_in;
   logic [IDX_W-1:0]    cmp_idx_ff,   cmp_idx_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic                present_ff,   present_in;
   logic                drop_ff,      drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   logic [IDX_W-1:0] idx_next;
   logic [CNT_W-1:0] idx_next_cnt;
   logic             hit;
   logic             last;

   assign idx_next     = cmp_idx_ff + IDX_W'(1);
   assign idx_next_cnt = CNT_W'(cmp_idx_ff) + CNT_ONE;
   assign hit          = (count_ff != '0) && (ram_rd_data == key_ff);
   assign last         = (count_ff == '0) || (idx_next_cnt == count_ff);
   assign req_ready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      cmp_idx_in   = cmp_idx_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_idx_ff - IDX_W'(1);
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_next;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_opcode;
               key_in      = req_key;
               present_in  = 1'b0;
               drop_in     = 1'b0;
               cmp_idx_in  = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               present_in = 1'b1;
               state_in   = ST_FINISH;
               if (op_ff == OP_REMOVE) begin
                  if (idx_next_cnt < count_ff) begin
                     ram_rd_en  = 1'b1;
                     cmp_idx_in = idx_next;
                     state_in   = ST_SHIFT;
                  end else begin
                     count_in = count_ff - CNT_ONE;
                  end
               end
            end else if (last) begin
               state_in = ST_FINISH;
               if (op_ff == OP_INSERT) begin
                  if (count_ff == CNT_CAP) begin
                     drop_in = 1'b1;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = count_ff[IDX_W-1:0];
                     ram_wr_data = key_ff;
                     count_in    = count_ff + CNT_ONE;
                  end
               end
            end else begin
               ram_rd_en  = 1'b1;
               cmp_idx_in = idx_next;
            end
         end
         ST_SHIFT: begin
            // move the entry just read one place down
            ram_wr_en = 1'b1;
            if (idx_next_cnt < count_ff) begin
               ram_rd_en  = 1'b1;
               cmp_idx_in = idx_next;
            end else begin
               count_in = count_ff - CNT_ONE;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.was_present = present_ff;
               rsp_data_in.entry_count = ENTRY_COUNT_W'(count_ff);
               rsp_data_in.full_drop   = drop_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      cmp_idx_ff  <= cmp_idx_in;
      present_ff  <= present_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_CAP)
      else $error("entry count above capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_drop_only_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.full_drop) |-> !rsp_data_ff.was_present)
      else $error("drop reported for a present key");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) < count_in))
      else $error("write beyond held entries");

   a_shift_read_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && ram_rd_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("shift read and write hit the same entry");
`endif

endmodule

`default_nettype wire

[rtl/small_integer_set_table_core.sv]
// Top level of the small integer set table: sequencer plus key memory.
// Depends on sist_pkg, sist_key_ram and sist_seq.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to CAPACITY distinct 32-bit keys in one synchronous memory, packed in
// insertion order. A request (insert, remove, find) is handled one at a time: the
// sequencer reads one entry per cycle from the memory's single read port; a remove
// shifts the entries that follow the hit, continuing where the scan stopped. The
// next request is taken once the sequencer is back in idle. A waiting response
// does not block the next request from being accepted, but that request's
// response is held back until the waiting one is taken. No clearing pass after
// reset.
module small_integer_set_table_core #(
   parameter int unsigned CAPACITY = sist_pkg::DEF_CAPACITY
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [sist_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [sist_pkg::KEY_W-1:0]    req_key,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_was_present,
   output logic        [sist_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   output logic                                      rsp_full_drop
);
   import sist_pkg::*;

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;
   rsp_type          rsp_data;

   sist_seq #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_key     (KEY_W'(req_key)),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   sist_key_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_was_present = rsp_data.was_present;
   assign rsp_entry_count = rsp_data.entry_count;
   assign rsp_full_drop   = rsp_data.full_drop;

endmodule

`default_nettype wire
